FILE: rtl/core/ufv_pkg.sv
// ufv_pkg: shared types and codes for the upwind finite-volume step block
// no dependencies
`timescale 1ns / 1ps

package ufv_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_EDGE   = 2'd1,
		REQ_COMMIT = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		NB_LOCAL    = 2'd0,
		NB_BOUNDARY = 2'd1,
		NB_GHOST    = 2'd2,
		NB_SPARE    = 2'd3
	} nb_t;

	localparam logic RES_FLUX   = 1'b0;
	localparam logic RES_COMMIT = 1'b1;

	localparam logic [0:0] CFG_TIME_STEP = 1'd0;
	localparam logic [0:0] CFG_BOUNDARY  = 1'd1;

	localparam int IN_W  = 32;
	localparam int IDX_W = 10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_FLUX,
		ST_DT,
		ST_LEN,
		ST_AL,
		ST_AR,
		ST_RD_L,
		ST_WR_L,
		ST_RD_R,
		ST_WR_R,
		ST_COMMIT,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/core/ufv_if.sv
// ufv_if: valid/ready channels for input requests and results
// depends on ufv_pkg
`timescale 1ns / 1ps

interface ufv_req_if;
	import ufv_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [IDX_W-1:0]  cell_index;
	logic signed [31:0] cell_value;
	logic [31:0]       inverse_area;
	logic signed [31:0] velocity;
	logic [31:0]       edge_length;
	logic [IDX_W-1:0]  left_cell;
	logic [IDX_W-1:0]  right_cell;
	logic [1:0]        neighbour_kind;
	logic signed [31:0] ghost_value;
	modport source (output valid, req_type, cell_index, cell_value, inverse_area, velocity,
		edge_length, left_cell, right_cell, neighbour_kind, ghost_value, input ready);
	modport sink (input valid, req_type, cell_index, cell_value, inverse_area, velocity,
		edge_length, left_cell, right_cell, neighbour_kind, ghost_value, output ready);
endinterface

interface ufv_res_if;
	import ufv_pkg::*;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [IDX_W-1:0]   result_index;
	logic signed [31:0] result_value;
	logic               saturated;
	modport source (output valid, result_kind, result_index, result_value, saturated,
		input ready);
	modport sink (input valid, result_kind, result_index, result_value, saturated,
		output ready);
endinterface

FILE: rtl/core/upwind_finite_volume_step_top.sv
// upwind finite-volume step: one transaction at a time, memories have a registered read
// the shared multiplier and the single read port of each store make the steps of an item
// run one after another
// arst_n clears the control state and the configuration registers; the change store is
// swept to zero after reset, no item is accepted during the sweep
`timescale 1ns / 1ps

module upwind_finite_volume_step_top import ufv_pkg::*; #(
	parameter int CELLS       = 1024,
	parameter int FRAC_BITS   = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	ufv_req_if.sink     req,
	ufv_res_if.source   res
);
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int VW = VALUE_WIDTH;

	typedef logic signed [VW-1:0] val_t;

	val_t                conc_mem [CELLS];
	logic [31:0]         area_mem [CELLS];
	val_t                chg_mem  [CELLS];

	state_t state_q, state_d;
	logic [AW:0]  clr_q;
	logic [30:0]  dt_q;
	logic signed [31:0] bnd_q;

	// item capture
	logic [1:0]  req_q;
	logic [AW-1:0] cell_q, left_q, right_q;
	logic [1:0]  kind_q;
	logic signed [31:0] vel_q, ghost_q;
	logic [31:0] len_q;
	logic        flag_q;
	val_t        flux_q, t_q, dl_q, dr_q;

	// memory read ports
	logic [AW-1:0] ra_c, ra_a, ra_x;
	val_t          conc_rd_q, chg_rd_q;
	logic [31:0]   area_rd_q;

	// multiplier
	val_t              ma;
	logic signed [IN_W:0] mb;
	val_t              mp;
	logic              mov;

	ufv_mul #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VW)) u_mul (
		.clk(clk), .a(ma), .b(mb), .p_q(mp), .ov_q(mov)
	);

	function automatic val_t sat_val(input logic signed [31:0] x);
		logic signed [47:0] w;
		logic signed [47:0] hi;
		w  = 48'(x);
		hi = (48'sd1 <<< (VW - 1)) - 48'sd1;
		if (w > hi)
			return val_t'(hi);
		else if (w < -hi - 48'sd1)
			return val_t'(-hi - 48'sd1);
		return val_t'(w);
	endfunction

	function automatic logic sat_ov(input logic signed [31:0] x);
		logic signed [47:0] w;
		logic signed [47:0] hi;
		w  = 48'(x);
		hi = (48'sd1 <<< (VW - 1)) - 48'sd1;
		return (w > hi) || (w < -hi - 48'sd1);
	endfunction

	function automatic val_t sadd(input val_t a, input val_t b, output logic f);
		logic signed [VW:0] s;
		s = {a[VW-1], a} + {b[VW-1], b};
		f = s[VW] != s[VW-1];
		return f ? (s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}}) : s[VW-1:0];
	endfunction

	logic accept;
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && clr_q[AW];

	// upwind selection and sums
	val_t up_v, sum_v;
	logic up_f, sum_f;
	val_t sub_v;
	logic sub_f;
	always_comb begin
		up_f = 1'b0;
		if (!vel_q[31] || kind_q == NB_LOCAL) up_v = conc_rd_q;
		else if (kind_q == NB_GHOST) begin
			up_v = sat_val(ghost_q);
			up_f = sat_ov(ghost_q);
		end else begin
			up_v = sat_val(bnd_q);
			up_f = sat_ov(bnd_q);
		end
		unique case (state_q)
			ST_FLUX: begin ma = up_v;   mb = {vel_q[31], vel_q}; end
			ST_DT:   begin ma = mp;     mb = {2'b00, dt_q}; end
			ST_LEN:  begin ma = mp;     mb = {1'b0, len_q}; end
			ST_AL:   begin ma = mp;     mb = {1'b0, area_rd_q}; end
			default: begin ma = t_q;    mb = {1'b0, area_rd_q}; end
		endcase
		if (state_q == ST_WR_R) sum_v = sadd(chg_rd_q, dr_q, sum_f);
		else sum_v = sadd(conc_rd_q, chg_rd_q, sum_f);
	end

	// read addresses
	always_comb begin
		ra_c = req_q == REQ_COMMIT ? cell_q : ((!vel_q[31]) ? left_q : right_q);
		ra_a = (state_q == ST_AL) ? right_q : left_q;
		ra_x = (state_q == ST_RD_R) ? right_q : (req_q == REQ_COMMIT ? cell_q : left_q);
	end

	always_ff @(posedge clk) begin
		conc_rd_q <= conc_mem[ra_c];
		area_rd_q <= area_mem[ra_a];
		chg_rd_q  <= chg_mem[ra_x];
		if (accept && req.req_type == REQ_LOAD) begin
			conc_mem[req.cell_index[AW-1:0]] <= sat_val(req.cell_value);
			area_mem[req.cell_index[AW-1:0]] <= req.inverse_area;
		end else if (state_q == ST_COMMIT)
			conc_mem[cell_q] <= sum_v;
		if (!clr_q[AW])
			chg_mem[clr_q[AW-1:0]] <= '0;
		else if (accept && req.req_type == REQ_LOAD)
			chg_mem[req.cell_index[AW-1:0]] <= '0;
		else if (state_q == ST_COMMIT)
			chg_mem[cell_q] <= '0;
		else if (state_q == ST_WR_L)
			chg_mem[left_q] <= sub_v;
		else if (state_q == ST_WR_R)
			chg_mem[right_q] <= sum_v;
	end

	// change minus product, saturating, done at full width
	always_comb begin
		logic signed [VW:0] s;
		s = {chg_rd_q[VW-1], chg_rd_q} - {dl_q[VW-1], dl_q};
		sub_f = s[VW] != s[VW-1];
		sub_v = sub_f ? (s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
			: s[VW-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) begin
				if (req.req_type == REQ_EDGE || req.req_type == REQ_COMMIT) state_d = ST_RD;
			end
			ST_RD:     state_d = (req_q == REQ_COMMIT) ? ST_COMMIT : ST_FLUX;
			ST_FLUX:   state_d = ST_DT;
			ST_DT:     state_d = ST_LEN;
			ST_LEN:    state_d = ST_AL;
			ST_AL:     state_d = (kind_q == NB_LOCAL) ? ST_AR : ST_RD_L;
			ST_AR:     state_d = ST_RD_L;
			ST_RD_L:   state_d = ST_WR_L;
			ST_WR_L:   state_d = (kind_q == NB_LOCAL) ? ST_RD_R : ST_OUT;
			ST_RD_R:   state_d = ST_WR_R;
			ST_WR_R:   state_d = ST_OUT;
			ST_COMMIT: state_d = ST_OUT;
			ST_OUT:    if (res.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q   <= '0;
			dt_q    <= '0;
			bnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (!clr_q[AW]) clr_q <= (clr_q == (AW+1)'(CELLS - 1)) ? {1'b1, {AW{1'b0}}}
				: clr_q + 1'b1;
			if (cfg_we) begin
				if (cfg_index == CFG_TIME_STEP) dt_q <= cfg_data[30:0];
				else bnd_q <= cfg_data;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req.req_type;
			cell_q  <= req.cell_index[AW-1:0];
			left_q  <= req.left_cell[AW-1:0];
			right_q <= req.right_cell[AW-1:0];
			kind_q  <= (req.neighbour_kind == NB_SPARE) ? NB_BOUNDARY : req.neighbour_kind;
			vel_q   <= req.velocity;
			ghost_q <= req.ghost_value;
			len_q   <= req.edge_length;
			flag_q  <= 1'b0;
		end
		unique case (state_q)
			ST_FLUX: flag_q <= flag_q | up_f;
			ST_DT:   begin flux_q <= mp; flag_q <= flag_q | mov; end
			ST_LEN:  flag_q <= flag_q | mov;
			ST_AL:   begin t_q <= mp; flag_q <= flag_q | mov; end
			ST_AR:   begin dl_q <= mp; flag_q <= flag_q | mov; end
			ST_RD_L: begin
				if (kind_q != NB_LOCAL) dl_q <= mp; else dr_q <= mp;
				flag_q <= flag_q | mov;
			end
			ST_WR_L:   flag_q <= flag_q | sub_f;
			ST_WR_R:   flag_q <= flag_q | sum_f;
			ST_COMMIT: begin flux_q <= sum_v; flag_q <= sum_f; end
			default: ;
		endcase
	end

	assign res.valid        = state_q == ST_OUT;
	assign res.result_kind  = (req_q == REQ_COMMIT) ? RES_COMMIT : RES_FLUX;
	assign res.result_index = IDX_W'(req_q == REQ_COMMIT ? cell_q : left_q);
	assign res.result_value = 32'(flux_q);
	assign res.saturated    = flag_q;
endmodule

FILE: rtl/core/ufv_mul.sv
// ufv_mul: registered fixed-point multiply, truncate toward zero, saturate
// depends on ufv_pkg
`timescale 1ns / 1ps

module ufv_mul import ufv_pkg::*; #(
	parameter int FRAC_BITS   = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic signed [VALUE_WIDTH-1:0] a,
	input  logic signed [IN_W:0]          b,
	output logic signed [VALUE_WIDTH-1:0] p_q,
	output logic                          ov_q
);
	localparam int PW = VALUE_WIDTH + IN_W + 1;

	logic                neg;
	logic [VALUE_WIDTH:0] ma;
	logic [IN_W:0]       mb;
	logic [PW-1:0]       prod;
	logic [PW-1:0]       q;
	logic [PW-1:0]       lim;

	always_comb begin
		neg  = a[VALUE_WIDTH-1] ^ b[IN_W];
		ma   = a[VALUE_WIDTH-1] ? -{a[VALUE_WIDTH-1], a} : {1'b0, a};
		mb   = b[IN_W] ? -b : b;
		prod = PW'(ma) * PW'(mb);
		q    = prod >> FRAC_BITS;
		lim  = (PW'(1) << (VALUE_WIDTH - 1)) - (neg ? PW'(0) : PW'(1));
	end

	always_ff @(posedge clk) begin
		if (q > lim) begin
			ov_q <= 1'b1;
			p_q  <= neg ? VALUE_WIDTH'(-lim) : VALUE_WIDTH'(lim);
		end else begin
			ov_q <= 1'b0;
			p_q  <= neg ? VALUE_WIDTH'(-q) : VALUE_WIDTH'(q);
		end
	end
endmodule
